@@ src/m4ct_pkg.sv @@
`default_nettype none
package m4ct_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int REG_W      = 64;
  localparam int ELEM_W     = 32;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int NUM_ROWS   = 4;
  localparam int TAG_W      = 2;

  // identity matrix, two signed halves per register
  localparam logic [NUM_REGS-1:0][REG_W-1:0] A_RESET = {
    64'h0001_0000_0000_0000,  // col3 rows23
    64'h0000_0000_0000_0000,  // col3 rows01
    64'h0000_0000_0001_0000,  // col2 rows23
    64'h0000_0000_0000_0000,  // col2 rows01
    64'h0000_0000_0000_0000,  // col1 rows23
    64'h0001_0000_0000_0000,  // col1 rows01
    64'h0000_0000_0000_0000,  // col0 rows23
    64'h0000_0000_0001_0000   // col0 rows01
  };

  typedef struct packed {
    logic ld_mul;
    logic ld_sum;
    logic ld_out;
  } lane_ctl_t;

endpackage
`default_nettype wire

@@ src/m4ct_lane.sv @@
`default_nettype none
module m4ct_lane #(
  parameter int FRAC_BITS = m4ct_pkg::FRAC_BITS
) (
  input  wire logic                                        clk,
  input  wire m4ct_pkg::lane_ctl_t                         ctl,
  input  wire logic [m4ct_pkg::NUM_ROWS-1:0][m4ct_pkg::ELEM_W-1:0] a_row,
  input  wire logic [m4ct_pkg::NUM_ROWS-1:0][m4ct_pkg::ELEM_W-1:0] b_col,
  output logic [m4ct_pkg::ELEM_W-1:0]                      result,
  output logic                                             clip
);
  import m4ct_pkg::*;

  logic signed [PROD_W-1:0] prod [NUM_ROWS];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  shifted;
  logic                     in_range;
  logic [ELEM_W-1:0]        result_next;

  // stage 1: one multiplier per column
  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      for (int k = 0; k < NUM_ROWS; k++) begin
        prod[k] <= $signed(a_row[k]) * $signed(b_col[k]);
      end
    end
  end

  // stage 2: full precision sum
  always_comb begin
    sum_next = '0;
    for (int k = 0; k < NUM_ROWS; k++) begin
      sum_next = sum_next + $signed({{(SUM_W-PROD_W){prod[k][PROD_W-1]}}, prod[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_sum) begin
      sum <= sum_next;
    end
  end

  // stage 3: floor shift and clip to 32 bits
  assign shifted  = sum >>> FRAC_BITS;
  assign in_range = (&shifted[SUM_W-1:ELEM_W-1]) | ~(|shifted[SUM_W-1:ELEM_W-1]);

  always_comb begin
    if (in_range) begin
      result_next = shifted[ELEM_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      result_next = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      result_next = {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      result <= result_next;
      clip   <= ~in_range;
    end
  end

endmodule
`default_nettype wire

@@ src/matrix4_column_transform.sv @@
// pipeline: a beat accepted on the slave side is registered in the multiply,
// sum, and shift and clip stages in that order before it is offered on the
// master side, each of them one register stage
// throughput: one beat per cycle, set by the four row lanes of four multipliers
// each; every stage moves on its own, so a stall only backs up full stages
// reset: synchronous, clears the stage valid bits and loads the identity matrix
`default_nettype none
module matrix4_column_transform #(
  parameter int FRAC_BITS = m4ct_pkg::FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // slave side
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [4*m4ct_pkg::ELEM_W-1:0]      s_tdata,   // b_row0, b_row1, b_row2, b_row3
  input  wire logic [7:0]                         s_tuser,   // column_tag, zero fill
  // master side
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [4*m4ct_pkg::ELEM_W-1:0]           m_tdata,   // r_row0, r_row1, r_row2, r_row3
  output logic [7:0]                              m_tuser,   // out_tag, saturated, zero fill
  // configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [m4ct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [m4ct_pkg::REG_W-1:0]         cfg_data
);
  import m4ct_pkg::*;

  // left matrix, column-major, two rows per register
  logic [NUM_REGS-1:0][REG_W-1:0] a_regs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_regs <= A_RESET;
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      // indexes past the last register are dropped
      a_regs[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // stage valid bits and flow control
  logic      v_mul, v_sum, v_out;
  logic      ld_mul, ld_sum, ld_out;
  lane_ctl_t ctl;

  assign ld_out   = v_sum && (!v_out || m_tready);
  assign ld_sum   = v_mul && (!v_sum || ld_out);
  assign s_tready = !v_mul || ld_sum;
  assign ld_mul   = s_tvalid && s_tready;
  assign ctl      = {ld_mul, ld_sum, ld_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
      v_sum <= 1'b0;
      v_out <= 1'b0;
    end else begin
      if (ld_mul) begin
        v_mul <= 1'b1;
      end else if (ld_sum) begin
        v_mul <= 1'b0;
      end
      if (ld_sum) begin
        v_sum <= 1'b1;
      end else if (ld_out) begin
        v_sum <= 1'b0;
      end
      if (ld_out) begin
        v_out <= 1'b1;
      end else if (m_tready) begin
        v_out <= 1'b0;
      end
    end
  end

  // column tag rides alongside the lanes
  logic [TAG_W-1:0] tag_mul, tag_sum, tag_out;

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      tag_mul <= s_tuser[TAG_W-1:0];
    end
    if (ld_sum) begin
      tag_sum <= tag_mul;
    end
    if (ld_out) begin
      tag_out <= tag_sum;
    end
  end

  // one lane per result row
  logic [NUM_ROWS-1:0][ELEM_W-1:0] b_col;
  logic [NUM_ROWS-1:0][ELEM_W-1:0] r_rows;
  logic [NUM_ROWS-1:0]             lane_clip;

  assign b_col = s_tdata;

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    logic [NUM_ROWS-1:0][ELEM_W-1:0] a_row;

    // A[r][c] sits in register 2c + r/2, half r%2
    for (genvar c = 0; c < NUM_ROWS; c++) begin : g_col
      assign a_row[c] = a_regs[2*c + r/2][ELEM_W*(r%2) +: ELEM_W];
    end

    m4ct_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .a_row  (a_row),
      .b_col  (b_col),
      .result (r_rows[r]),
      .clip   (lane_clip[r])
    );
  end

  // merge: any clipped lane flags the whole column
  logic saturated;
  assign saturated = |lane_clip;

  assign m_tvalid = v_out;
  assign m_tdata  = r_rows;
  assign m_tuser  = {{(8-TAG_W-1){1'b0}}, saturated, tag_out};

  // a flagged column has at least one element at a rail
  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && saturated |->
      r_rows[0] == 32'h7fff_ffff || r_rows[0] == 32'h8000_0000 ||
      r_rows[1] == 32'h7fff_ffff || r_rows[1] == 32'h8000_0000 ||
      r_rows[2] == 32'h7fff_ffff || r_rows[2] == 32'h8000_0000 ||
      r_rows[3] == 32'h7fff_ffff || r_rows[3] == 32'h8000_0000)
    else $error("saturated flag without a clipped element");

  // an empty first stage always takes a beat
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !v_mul |-> s_tready)
    else $error("slave side stalled with empty multiply stage");

  // a load into the output register shows a beat next cycle
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    ld_out |=> m_tvalid)
    else $error("output load lost");

  // a beat in the sum stage moves on or stays
  a_sum_kept: assert property (@(posedge clk) disable iff (rst)
    v_sum && !ld_out |=> v_sum)
    else $error("sum stage beat dropped");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire
